[rtl/kurq_pkg.sv]
// shared types and constants of the keyboard usart receive queues
`default_nettype none

package kurq_pkg;

    // input mode codes
    localparam logic [2:0] MODE_KEY    = 3'd0;
    localparam logic [2:0] MODE_REPLY  = 3'd1;
    localparam logic [2:0] MODE_TICK   = 3'd2;
    localparam logic [2:0] MODE_WDATA  = 3'd3;
    localparam logic [2:0] MODE_WCMD   = 3'd4;
    localparam logic [2:0] MODE_RDATA  = 3'd5;
    localparam logic [2:0] MODE_RSTAT  = 3'd6;

    localparam logic [7:0] DATA_RESET    = 8'hFF;
    localparam logic [7:0] STAT_READ_OR  = 8'h85;
    localparam logic [7:0] STAT_OVERRUN  = 8'h10;
    localparam logic [7:0] STAT_READY    = 8'h02;
    localparam logic [7:0] STAT_ERR_MASK = 8'h38;
    localparam logic [7:0] CMD_TX_EN     = 8'h01;
    localparam logic [7:0] CMD_KBD_RUN   = 8'h08;
    localparam logic [7:0] CMD_ERR_CLR   = 8'h10;
    localparam logic [7:0] REPLY_ACK     = 8'hFA;
    localparam logic [7:0] REPLY_RESEND  = 8'hFC;

    typedef enum logic [2:0] {
        OP_KEY,
        OP_REPLY,
        OP_TICK,
        OP_WDATA,
        OP_WCMD,
        OP_RDATA,
        OP_RSTAT,
        OP_NONE
    } t_op;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] byte_value;
    } t_in;

    typedef struct packed {
        logic [7:0] read_value;
        logic       irq_level;
        logic       send_valid;
        logic [7:0] send_byte;
        logic       kbd_reset_pulse;
    } t_out;

    typedef struct packed {
        t_op        op;
        logic       flush;
        logic [7:0] value;
    } t_item;

endpackage

`default_nettype wire

[rtl/kurq_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module kurq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/kurq_front.sv]
// front end: accepts input items, decodes them and queues them for the back end
`default_nettype none

module kurq_front import kurq_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_in   i_in_data,
    output      logic  o_in_stall,
    output      logic  o_item_valid,
    output      t_item o_item,
    input  wire logic  i_take
);

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    t_item      w_dec;

    always_comb begin
        w_dec.value = i_in_data.byte_value;
        w_dec.flush = (i_in_data.byte_value == REPLY_ACK)
                   || (i_in_data.byte_value == REPLY_RESEND);
        unique case (i_in_data.mode)
            MODE_KEY:   w_dec.op = OP_KEY;
            MODE_REPLY: w_dec.op = OP_REPLY;
            MODE_TICK:  w_dec.op = OP_TICK;
            MODE_WDATA: w_dec.op = OP_WDATA;
            MODE_WCMD:  w_dec.op = OP_WCMD;
            MODE_RDATA: w_dec.op = OP_RDATA;
            MODE_RSTAT: w_dec.op = OP_RSTAT;
            default:    w_dec.op = OP_NONE;
        endcase
    end

    assign o_in_stall   = r_cnt[1];
    assign w_push       = i_in_valid && !o_in_stall;
    assign o_item_valid = r_cnt != 2'd0;
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_dec;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_take) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_take};
        end
    end

endmodule

`default_nettype wire

[rtl/kurq_back.sv]
// back end: usart state, reply and key fifos, result register
`default_nettype none

module kurq_back import kurq_pkg::*; #(
    parameter int REPLY_DEPTH = 8,
    parameter int KEY_DEPTH   = 128
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_item_valid,
    input  wire t_item i_item,
    output      logic  o_take,
    output      logic  o_out_valid,
    output      t_out  o_out_data,
    input  wire logic  i_out_stall
);

    localparam int RA  = $clog2(REPLY_DEPTH);
    localparam int KA  = $clog2(KEY_DEPTH);
    localparam int RCW = RA + 1;
    localparam int KCW = KA + 1;
    localparam logic [RCW-1:0] REPLY_FULL = RCW'(REPLY_DEPTH);
    localparam logic [KCW-1:0] KEY_FULL   = KCW'(KEY_DEPTH);

    typedef enum logic [1:0] {
        ST_EXEC = 2'b01,
        ST_FILL = 2'b10
    } t_state;

    t_state         r_state, n_state;
    logic [7:0]     r_data_hold, n_data_hold;
    logic [7:0]     r_status, n_status;
    logic [7:0]     r_cmd, n_cmd;
    logic           r_irq, n_irq;
    logic [RA-1:0]  r_reply_head, n_reply_head;
    logic [RCW-1:0] r_reply_count, n_reply_count;
    logic [KA-1:0]  r_key_head, n_key_head;
    logic [KCW-1:0] r_key_count, n_key_count;
    logic           r_from_reply, n_from_reply;
    logic           r_out_valid, n_out_valid;
    t_out           r_out, n_out;

    logic           w_out_free;
    logic           w_reply_we, w_key_we;
    logic [RA-1:0]  w_reply_waddr;
    logic [KA-1:0]  w_key_waddr;
    logic [7:0]     w_reply_rdata, w_key_rdata;
    logic [RCW-1:0] w_reply_eff;
    logic [RCW-1:0] w_reply_tail;
    logic [KCW-1:0] w_key_tail;
    logic [RCW-1:0] w_reply_next;
    logic [KCW-1:0] w_key_next;

    kurq_ram #(.WIDTH(8), .DEPTH(REPLY_DEPTH)) u_reply_ram (
        .i_clk   (i_clk),
        .i_we    (w_reply_we),
        .i_waddr (w_reply_waddr),
        .i_wdata (i_item.value),
        .i_raddr (r_reply_head),
        .o_rdata (w_reply_rdata)
    );

    kurq_ram #(.WIDTH(8), .DEPTH(KEY_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_key_waddr),
        .i_wdata (i_item.value),
        .i_raddr (r_key_head),
        .o_rdata (w_key_rdata)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_take     = (r_state == ST_EXEC) && i_item_valid && w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // tail positions, wrapped for any depth
    assign w_reply_eff  = i_item.flush ? '0 : r_reply_count;
    assign w_reply_tail = {1'b0, r_reply_head} + w_reply_eff;
    assign w_key_tail   = {1'b0, r_key_head} + r_key_count;
    assign w_reply_next = {1'b0, r_reply_head} + RCW'(1);
    assign w_key_next   = {1'b0, r_key_head} + KCW'(1);

    always_comb begin
        w_reply_waddr = (w_reply_tail >= REPLY_FULL) ? RA'(w_reply_tail - REPLY_FULL)
                                                     : w_reply_tail[RA-1:0];
        w_key_waddr   = (w_key_tail >= KEY_FULL) ? KA'(w_key_tail - KEY_FULL)
                                                 : w_key_tail[KA-1:0];
    end

    always_comb begin
        n_state       = r_state;
        n_data_hold   = r_data_hold;
        n_status      = r_status;
        n_cmd         = r_cmd;
        n_irq         = r_irq;
        n_reply_head  = r_reply_head;
        n_reply_count = r_reply_count;
        n_key_head    = r_key_head;
        n_key_count   = r_key_count;
        n_from_reply  = r_from_reply;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out         = r_out;
        w_reply_we    = 1'b0;
        w_key_we      = 1'b0;

        unique case (r_state)
            ST_FILL: begin
                // ram read data for the head captured in the previous cycle
                n_data_hold = r_from_reply ? w_reply_rdata : w_key_rdata;
                n_state     = ST_EXEC;
            end
            ST_EXEC: begin
                if (o_take) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    unique case (i_item.op)
                        OP_KEY: begin
                            if (r_key_count < KEY_FULL) begin
                                w_key_we    = 1'b1;
                                n_key_count = r_key_count + KCW'(1);
                            end else begin
                                n_status = r_status | STAT_OVERRUN;
                            end
                        end
                        OP_REPLY: begin
                            n_reply_count = w_reply_eff;
                            if (w_reply_eff < REPLY_FULL) begin
                                w_reply_we    = 1'b1;
                                n_reply_count = w_reply_eff + RCW'(1);
                            end
                        end
                        OP_TICK: begin
                            if (r_reply_count != '0 || r_key_count != '0) begin
                                if ((r_status & STAT_READY) == 8'h00) begin
                                    n_status = r_status | STAT_READY;
                                    n_state  = ST_FILL;
                                    if (r_reply_count != '0) begin
                                        n_from_reply  = 1'b1;
                                        n_reply_count = r_reply_count - RCW'(1);
                                        n_reply_head  = (w_reply_next == REPLY_FULL)
                                                      ? '0 : w_reply_next[RA-1:0];
                                    end else begin
                                        n_from_reply = 1'b0;
                                        n_key_count  = r_key_count - KCW'(1);
                                        n_key_head   = (w_key_next == KEY_FULL)
                                                     ? '0 : w_key_next[KA-1:0];
                                    end
                                end
                                n_irq = 1'b1;
                            end
                        end
                        OP_WDATA: begin
                            if ((r_cmd & CMD_TX_EN) != 8'h00) begin
                                n_out.send_valid = 1'b1;
                                n_out.send_byte  = i_item.value;
                            end
                        end
                        OP_WCMD: begin
                            // falling edge of the keyboard run bit resets the queues
                            if ((i_item.value & CMD_KBD_RUN) == 8'h00
                                && (r_cmd & CMD_KBD_RUN) != 8'h00) begin
                                n_status              = 8'h00;
                                n_reply_count         = '0;
                                n_key_count           = '0;
                                n_out.kbd_reset_pulse = 1'b1;
                            end
                            if ((i_item.value & CMD_ERR_CLR) != 8'h00) begin
                                n_status = n_status & ~STAT_ERR_MASK;
                            end
                            n_cmd = i_item.value;
                        end
                        OP_RDATA: begin
                            n_status         = r_status & ~STAT_READY;
                            n_irq            = 1'b0;
                            n_out.read_value = r_data_hold;
                        end
                        OP_RSTAT: begin
                            n_out.read_value = r_status | STAT_READ_OR;
                        end
                        OP_NONE: begin
                        end
                    endcase
                    n_out.irq_level = n_irq;
                end
            end
            default: begin
                n_state = ST_EXEC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_from_reply <= n_from_reply;
        if (!i_rst_n) begin
            r_state       <= ST_EXEC;
            r_data_hold   <= DATA_RESET;
            r_status      <= 8'h00;
            r_cmd         <= 8'h00;
            r_irq         <= 1'b0;
            r_reply_head  <= '0;
            r_reply_count <= '0;
            r_key_head    <= '0;
            r_key_count   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_data_hold   <= n_data_hold;
            r_status      <= n_status;
            r_cmd         <= n_cmd;
            r_irq         <= n_irq;
            r_reply_head  <= n_reply_head;
            r_reply_count <= n_reply_count;
            r_key_head    <= n_key_head;
            r_key_count   <= n_key_count;
            r_out_valid   <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[rtl/keyboard_usart_receive_queues.sv]
// an item's result is registered in the result register as the item is taken from the queue
// one item per cycle unless the result register stalls; a tick that moves a byte is followed
//   by a fill state, loading the data register from the registered read port of the fifo ram
// a two-entry queue sits between decode and execution; the result register frees on transfer
// reset: synchronous active-low i_rst_n empties both fifos and the queue, data register 0xff
`default_nettype none

module keyboard_usart_receive_queues import kurq_pkg::*; #(
    parameter int REPLY_DEPTH = 8,
    parameter int KEY_DEPTH   = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_in  i_in_data,
    output      logic o_in_stall,
    output      logic o_out_valid,
    output      t_out o_out_data,
    input  wire logic i_out_stall
);

    logic  w_item_valid;
    t_item w_item;
    logic  w_take;

    kurq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_take       (w_take)
    );

    kurq_back #(
        .REPLY_DEPTH (REPLY_DEPTH),
        .KEY_DEPTH   (KEY_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_take       (w_take),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_item_valid)
        else $error("back end took from an empty queue");

    a_take_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> !(o_out_valid && i_out_stall))
        else $error("back end took an item while the result register is stalled");

    a_pulse_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kbd_reset_pulse
            |-> o_out_data.read_value == 8'h00 && !o_out_data.send_valid)
        else $error("keyboard reset pulse mixed with a read or send result");

endmodule

`default_nettype wire
